[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is high.
`define JFPG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("jfpg assertion failed");

// Property checked on every rising clock edge, reset included.
`define JFPG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("jfpg assertion failed");

`endif

[sv/jfpg_pkg.sv]
package jfpg_pkg;

   // Fixed-point format and coordinate width.
   localparam int FRAC_BITS  = 28;
   localparam int COORD_BITS = 12;

   // Widths fixed by the interface.
   localparam int PIXEL_W = 12;
   localparam int Z_W     = 32;
   localparam int STEP_W  = 31;
   localparam int CNT_W   = 8;
   localparam int COLOR_W = 8;
   localparam int GREEN_W = 7;
   localparam int WIDE_W  = 64;
   localparam int MAP_W   = COORD_BITS + STEP_W;

   // Number of restoring division cells, one per quotient bit.
   localparam int DIV_STEPS = COLOR_W;

   localparam logic signed [WIDE_W-1:0] TWO_FIX  = WIDE_W'(2) << FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] FOUR_FIX = WIDE_W'(4) << FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] SAT_HI   = WIDE_W'(64'sd2147483647);
   localparam logic signed [WIDE_W-1:0] SAT_LO   = -WIDE_W'(64'sd2147483648);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_C_REAL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_C_IMAG   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER = 3'd4;

   // Reset values of the configuration registers.
   localparam logic signed [Z_W-1:0] C_REAL_RST   = 32'sd95294587;
   localparam logic signed [Z_W-1:0] C_IMAG_RST   = 32'sd95294587;
   localparam logic [STEP_W-1:0]     STEP_X_RST   = 31'd1342177;
   localparam logic [STEP_W-1:0]     STEP_Y_RST   = 31'd1789570;
   localparam logic [CNT_W-1:0]      MAX_ITER_RST = 8'd100;

   typedef struct packed {
      logic signed [Z_W-1:0] c_real;
      logic signed [Z_W-1:0] c_imag;
      logic [STEP_W-1:0]     step_x;
      logic [STEP_W-1:0]     step_y;
      logic [CNT_W-1:0]      max_iter;
   } cfg_type;

   // Item travelling down the division chain.
   typedef struct packed {
      logic               valid;
      logic [CNT_W-1:0]   rem;
      logic [CNT_W-1:0]   num;
      logic [COLOR_W-1:0] quo;
      logic [CNT_W-1:0]   divisor;
      logic [CNT_W-1:0]   count;
   } div_cell_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [Z_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [Z_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[Z_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[Z_W-1:0];
      end else begin
         r = v[Z_W-1:0];
      end
      return r;
   endfunction

endpackage

[sv/jfpg_div_cell.sv]
module jfpg_div_cell import jfpg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  div_cell_type cell_in,
   output div_cell_type cell_out
);

   div_cell_type      cell_ff;
   div_cell_type      cell_in_calc;
   logic [CNT_W:0]    trial;
   logic              take;

   // One restoring step: bring down the next numerator bit and subtract
   // the divisor when it fits. The remainder stays below the divisor.
   always_comb begin
      trial = {cell_in.rem, cell_in.num[CNT_W-1]};
      take  = (trial >= {1'b0, cell_in.divisor});
      cell_in_calc         = cell_in;
      cell_in_calc.rem     = take ? CNT_W'(trial - {1'b0, cell_in.divisor}) : trial[CNT_W-1:0];
      cell_in_calc.num     = {cell_in.num[CNT_W-2:0], 1'b0};
      cell_in_calc.quo     = {cell_in.quo[COLOR_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (advance) begin
         cell_ff.rem     <= cell_in_calc.rem;
         cell_ff.num     <= cell_in_calc.num;
         cell_ff.quo     <= cell_in_calc.quo;
         cell_ff.divisor <= cell_in_calc.divisor;
         cell_ff.count   <= cell_in_calc.count;
      end
   end

   assign cell_out = cell_ff;

endmodule

[sv/jfpg_escape_engine.sv]
module jfpg_escape_engine import jfpg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [PIXEL_W-1:0] pixel_x,
   input  logic [PIXEL_W-1:0] pixel_y,
   input  logic               advance,
   output div_cell_type       seed
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MAP  = 6'b000010,
      ST_SAT  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_ADD  = 6'b010000,
      ST_DONE = 6'b100000
   } eng_state_type;

   eng_state_type state_ff, state_in;

   logic [COORD_BITS-1:0]     px_ff, py_ff;
   logic [MAP_W-1:0]          prod_x_ff, prod_y_ff;
   logic signed [Z_W-1:0]     zr_ff, zi_ff;
   logic signed [WIDE_W-1:0]  sq_r_ff, sq_i_ff, cross_ff;
   logic [CNT_W-1:0]          count_ff;

   logic signed [WIDE_W-1:0]  sq_r_sh, sq_i_sh, cross_sh, mag;
   logic signed [WIDE_W-1:0]  c_real_ext, c_imag_ext, map_x, map_y;
   logic signed [Z_W-1:0]     zr_new, zi_new;
   logic                      escape;
   logic [CNT_W-1:0]          count_inc;
   logic [2*CNT_W-1:0]        scaled;

   // Arithmetic right shifts give the floor of each product.
   always_comb begin
      sq_r_sh    = sq_r_ff >>> FRAC_BITS;
      sq_i_sh    = sq_i_ff >>> FRAC_BITS;
      cross_sh   = cross_ff >>> (FRAC_BITS - 1);
      mag        = sq_r_sh + sq_i_sh;
      escape     = (mag > FOUR_FIX);
      c_real_ext = $signed({{(WIDE_W-Z_W){cfg.c_real[Z_W-1]}}, cfg.c_real});
      c_imag_ext = $signed({{(WIDE_W-Z_W){cfg.c_imag[Z_W-1]}}, cfg.c_imag});
      zr_new     = sat32(sq_r_sh - sq_i_sh + c_real_ext);
      zi_new     = sat32(cross_sh + c_imag_ext);
      map_x      = $signed({{(WIDE_W-MAP_W){1'b0}}, prod_x_ff}) - TWO_FIX;
      map_y      = $signed({{(WIDE_W-MAP_W){1'b0}}, prod_y_ff}) - TWO_FIX;
      count_inc  = count_ff + CNT_W'(1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            state_in = (cfg.max_iter == '0) ? ST_DONE : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = (escape || count_inc == cfg.max_iter) ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               px_ff <= pixel_x[COORD_BITS-1:0];
               py_ff <= pixel_y[COORD_BITS-1:0];
            end
         end
         ST_MAP: begin
            prod_x_ff <= MAP_W'(px_ff) * MAP_W'(cfg.step_x);
            prod_y_ff <= MAP_W'(py_ff) * MAP_W'(cfg.step_y);
         end
         ST_SAT: begin
            zr_ff    <= sat32(map_x);
            zi_ff    <= sat32(map_y);
            count_ff <= '0;
         end
         ST_MUL: begin
            sq_r_ff  <= WIDE_W'(zr_ff * zr_ff);
            sq_i_ff  <= WIDE_W'(zi_ff * zi_ff);
            cross_ff <= WIDE_W'(zr_ff * zi_ff);
         end
         ST_ADD: begin
            if (!escape) begin
               zr_ff    <= zr_new;
               zi_ff    <= zi_new;
               count_ff <= count_inc;
            end
         end
         default: begin
         end
      endcase
   end

   // count*255 split into the first remainder and the remaining numerator bits.
   assign scaled = {count_ff, CNT_W'(0)} - {CNT_W'(0), count_ff};

   always_comb begin
      seed.valid   = (state_ff == ST_DONE);
      seed.rem     = scaled[2*CNT_W-1:CNT_W];
      seed.num     = scaled[CNT_W-1:0];
      seed.quo     = '0;
      seed.divisor = cfg.max_iter;
      seed.count   = count_ff;
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

[sv/julia_fractal_pixel_generator.sv]
// Julia-set escape-time pixel generator. Each item on the req_ channel is a
// pixel (column, row); the block maps it to z = (x*step_x - 2) + i(y*step_y - 2)
// in signed fixed point with 28 fraction bits, iterates z = z*z + c while
// |z|^2 <= 4 and the count is below max_iter, and returns one item on the rsp_
// channel with the count and a color: red = floor(count*255/max_iter),
// green = red/2, blue = 255 - red. Products are floored, and z saturates to
// the signed 32-bit range. Every pass of the shared multiply/add loop runs a
// product step for the three products and then an update step for the update
// and escape test. A pixel that escapes runs one more pass than its count,
// since the escape test costs one more pass. Around the loop the engine steps
// through mapping, saturation of the start point, handing the count to the
// division chain, and idle before it takes the next pixel. The hand-off waits
// while the output is stalled. The result then passes an eight-cell division
// chain and the output register. Configuration is written through
// csr_we/csr_index/csr_wdata; the user must write it only while no pixel is
// in flight, as the block itself does not enforce this.
module julia_fractal_pixel_generator import jfpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_W-1:0]    req_pixel_x,
   input  logic [PIXEL_W-1:0]    req_pixel_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CNT_W-1:0]      rsp_iter_count,
   output logic [COLOR_W-1:0]    rsp_red,
   output logic [GREEN_W-1:0]    rsp_green,
   output logic [COLOR_W-1:0]    rsp_blue,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type             cfg_ff;
   div_cell_type        stage [0:DIV_STEPS];
   logic                advance;
   logic                rsp_valid_ff;
   logic [CNT_W-1:0]    iter_count_ff;
   logic [COLOR_W-1:0]  red_ff;
   logic [COLOR_W-1:0]  red_calc;

   // Configuration registers. Writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_real   <= C_REAL_RST;
         cfg_ff.c_imag   <= C_IMAG_RST;
         cfg_ff.step_x   <= STEP_X_RST;
         cfg_ff.step_y   <= STEP_Y_RST;
         cfg_ff.max_iter <= MAX_ITER_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_C_REAL: begin
               cfg_ff.c_real <= $signed(csr_wdata[Z_W-1:0]);
            end
            CSR_C_IMAG: begin
               cfg_ff.c_imag <= $signed(csr_wdata[Z_W-1:0]);
            end
            CSR_STEP_X: begin
               cfg_ff.step_x <= csr_wdata[STEP_W-1:0];
            end
            CSR_STEP_Y: begin
               cfg_ff.step_y <= csr_wdata[STEP_W-1:0];
            end
            CSR_MAX_ITER: begin
               cfg_ff.max_iter <= csr_wdata[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The whole back end moves together whenever the output register can
   // take whatever leaves the last cell; otherwise every stage holds.
   assign advance = !rsp_valid_ff || rsp_ready;

   jfpg_escape_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .pixel_x   (req_pixel_x),
      .pixel_y   (req_pixel_y),
      .advance   (advance),
      .seed      (stage[0])
   );

   // Each cell produces one quotient bit of count*255/max_iter, most
   // significant first, and hands its partial remainder to the next cell.
   for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div
      jfpg_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (stage[gi]),
         .cell_out (stage[gi+1])
      );
   end

   // With a zero limit the chain sees a zero divisor; red is defined as zero.
   assign red_calc = (stage[DIV_STEPS].divisor == '0) ? '0 : stage[DIV_STEPS].quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage[DIV_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage[DIV_STEPS].valid) begin
         iter_count_ff <= stage[DIV_STEPS].count;
         red_ff        <= red_calc;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iter_count = iter_count_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = red_ff[COLOR_W-1:1];
   assign rsp_blue       = ~red_ff;

endmodule

[sv/jfpg_checker.sv]
`include "assert_macros.svh"

module jfpg_checker import jfpg_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [PIXEL_W-1:0]    req_pixel_x,
   input logic [PIXEL_W-1:0]    req_pixel_y,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CNT_W-1:0]      rsp_iter_count,
   input logic [COLOR_W-1:0]    rsp_red,
   input logic [GREEN_W-1:0]    rsp_green,
   input logic [COLOR_W-1:0]    rsp_blue
);

   // A pending response is neither withdrawn nor changed.
   `JFPG_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_iter_count) && $stable(rsp_red))

   // A waiting pixel keeps its coordinates until it is taken.
   `JFPG_ASSERT(a_req_hold, clock, reset,
      req_valid && !req_ready |=> req_valid && $stable(req_pixel_x) && $stable(req_pixel_y))

   // The engine works on one pixel at a time, so it is busy after a take.
   `JFPG_ASSERT(a_req_busy, clock, reset, req_valid && req_ready |=> !req_ready)

   // Green and blue follow from red on every valid response.
   `JFPG_ASSERT(a_color, clock, reset, rsp_valid |-> (rsp_green == rsp_red[COLOR_W-1:1]) && (rsp_blue == ~rsp_red))

   // Reset leaves the block empty and ready for a pixel.
   `JFPG_ASSERT_ALWAYS(a_reset, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind julia_fractal_pixel_generator jfpg_checker u_jfpg_checker (.*);
